// File: src/sbc_pkg.sv
// Shared types and constants for the semielliptic band chemisorption block.
// No dependencies.
package sbc_pkg;

  // pi scaled by 2^30, rounded
  localparam logic [31:0] PI_Q = 32'd3373259426;
  // right shift applied to the lambda quotient
  localparam int LAMBDA_SHIFT = 46;

  localparam logic [31:0] COUPLING_RESET   = 32'd65536;
  localparam logic [31:0] BAND_WIDTH_RESET = 32'd65536;

  // register indexes on the configuration port
  localparam logic [1:0] REG_COUPLING    = 2'd0;
  localparam logic [1:0] REG_BAND_CENTRE = 2'd1;
  localparam logic [1:0] REG_BAND_WIDTH  = 2'd2;

  typedef enum logic [1:0] {
    REGION_INSIDE = 2'd0,
    REGION_ABOVE  = 2'd1,
    REGION_BELOW  = 2'd2
  } region_t;

endpackage

// File: src/semielliptic_band_chemisorption.sv
// Semielliptic band chemisorption evaluator: top level, fully pipelined.
// Depends on sbc_pkg for constants and the region code type.
//
// Usage:
//   Input channel (energy_valid / energy_stall / energy) carries one signed
//   Q8.16 energy sample per transaction. Output channel (result_valid /
//   result_stall) carries delta_value, lambda_value, region and saturated.
//   A transaction completes at a rising edge with valid high and stall low.
//   Configuration (coupling, band_centre, band_width) is written over the
//   APB port at byte addresses 0, 4 and 8; change it only when no
//   transaction is in flight.
// Throughput: one sample per cycle, sustained while result_stall is low.
// Pipeline: the square root (one root bit per stage, ENERGY_WIDTH stages)
//   is followed by the two restoring dividers (one quotient bit per stage,
//   RESULT_WIDTH stages).
// Stall: the whole pipeline holds while a result waits under result_stall;
//   energy_stall is raised in those cycles only, so no transaction is lost
//   or repeated and the waiting result holds steady.
// Reset: rst (synchronous) drops every in-flight transaction and loads the
//   register reset values (coupling 1.0 eV, centre 0, half width 1.0 eV).
//   After a write or reset, values derived from the registers settle in turn
//   through v2/w2, pv_lo/pv_hi and pi_v2, well before a sample needs them.
module semielliptic_band_chemisorption #(
  parameter int ENERGY_WIDTH = 24,
  parameter int RESULT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              energy_valid,
  output logic                              energy_stall,
  input  logic signed [ENERGY_WIDTH-1:0]    energy,
  // output channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [RESULT_WIDTH-2:0]           delta_value,
  output logic signed [RESULT_WIDTH-1:0]    lambda_value,
  output logic [1:0]                        region,
  output logic                              saturated,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int EW   = ENERGY_WIDTH;
  localparam int RW   = RESULT_WIDTH;
  localparam int HW   = EW - 1;            // coupling / half width width
  localparam int V2W  = 2 * HW;            // coupling squared
  localparam int RADW = 2 * EW;            // square root radicand
  localparam int PW   = 32 + HW;           // pi times one half of v2
  localparam int PVW  = 32 + V2W;          // pi times v2
  localparam int CH   = (PVW + 2) / 3;     // chunk of pi*v2 per multiplier
  localparam int PLW  = CH + EW;           // lambda partial product
  localparam int PDW  = HW + EW;           // delta partial product
  localparam int NDW  = 1 + V2W + EW;      // delta numerator
  localparam int NLW  = PVW + EW;          // lambda numerator
  localparam int DDW  = ((NDW > V2W + RW) ? NDW : V2W + RW) + 1;
  localparam int LDW  = ((NLW > HW + sbc_pkg::LAMBDA_SHIFT + RW) ? NLW :
                         HW + sbc_pkg::LAMBDA_SHIFT + RW) + 1;
  localparam int NST  = EW + RW + 8;       // pipeline stages incl. output

  // ---------------------------------------------------------------------
  // Configuration registers and derived constants
  // ---------------------------------------------------------------------
  logic [HW-1:0]        coupling;
  logic signed [EW-1:0] band_centre;
  logic [HW-1:0]        band_width;
  logic [HW-1:0]        w_eff;
  logic [V2W-1:0]       v2;
  logic [V2W-1:0]       w2;
  logic [PW-1:0]        pv_lo;
  logic [PW-1:0]        pv_hi;
  logic [PVW-1:0]       pi_v2;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // a zero half width acts as the smallest nonzero one
  assign w_eff     = (band_width == '0) ? HW'(1) : band_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling    <= HW'(sbc_pkg::COUPLING_RESET);
      band_centre <= '0;
      band_width  <= HW'(sbc_pkg::BAND_WIDTH_RESET);
    end else if (cfg_write) begin
      case (paddr[3:2])
        sbc_pkg::REG_COUPLING:    coupling    <= pwdata[HW-1:0];
        sbc_pkg::REG_BAND_CENTRE: band_centre <= pwdata[EW-1:0];
        sbc_pkg::REG_BAND_WIDTH:  band_width  <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sbc_pkg::REG_COUPLING:    prdata = 32'(coupling);
      sbc_pkg::REG_BAND_CENTRE: prdata = 32'(band_centre);
      sbc_pkg::REG_BAND_WIDTH:  prdata = 32'(band_width);
      default:                  prdata = '0;
    endcase
  end

  // Derived values follow the registers: squares, then pi*v2 in two halves.
  always_ff @(posedge clk) begin
    v2    <= V2W'(coupling) * V2W'(coupling);
    w2    <= V2W'(w_eff) * V2W'(w_eff);
    pv_lo <= PW'(sbc_pkg::PI_Q) * PW'(v2[HW-1:0]);
    pv_hi <= PW'(sbc_pkg::PI_Q) * PW'(v2[V2W-1:HW]);
    pi_v2 <= PVW'(pv_lo) + (PVW'(pv_hi) << HW);
  end

  // ---------------------------------------------------------------------
  // Pipeline control: one enable, valid bits travel with the data
  // ---------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic           en;

  assign en           = !(vld[NST-1] && result_stall);
  assign energy_stall = !en;
  assign result_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], energy_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: offset from band centre, magnitude, band test
  // ---------------------------------------------------------------------
  logic [EW:0]   dif;
  logic [EW:0]   dif_neg;
  logic [EW-1:0] ad_c;
  logic [EW-1:0] s1_ad;
  logic          s1_neg, s1_pos, s1_in;

  assign dif     = {energy[EW-1], energy} - {band_centre[EW-1], band_centre};
  assign dif_neg = ~dif + 1'b1;
  assign ad_c    = dif[EW] ? dif_neg[EW-1:0] : dif[EW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ad  <= ad_c;
      s1_neg <= dif[EW];
      s1_pos <= !dif[EW] && (dif != '0);
      s1_in  <= ad_c <= {1'b0, w_eff};
    end
  end

  // Stage 2: square the offset
  logic [RADW-1:0] s2_ad2;
  logic [EW-1:0]   s2_ad;
  logic            s2_neg, s2_pos, s2_in;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ad2 <= RADW'(s1_ad) * RADW'(s1_ad);
      s2_ad  <= s1_ad;
      s2_neg <= s1_neg;
      s2_pos <= s1_pos;
      s2_in  <= s1_in;
    end
  end

  // Stage 3: radicand w^2 - d^2 inside the band, d^2 - w^2 outside
  logic [RADW-1:0] s3_rad;
  logic [EW-1:0]   s3_ad;
  logic            s3_neg, s3_pos, s3_in;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rad <= s2_in ? (RADW'(w2) - s2_ad2) : (s2_ad2 - RADW'(w2));
      s3_ad  <= s2_ad;
      s3_neg <= s2_neg;
      s3_pos <= s2_pos;
      s3_in  <= s2_in;
    end
  end

  // ---------------------------------------------------------------------
  // Square root: one root bit per stage, two radicand bits consumed
  // ---------------------------------------------------------------------
  logic [RADW-1:0] sq_rad  [EW];
  logic [EW+1:0]   sq_rem  [EW];
  logic [EW-1:0]   sq_root [EW];
  logic [EW-1:0]   sq_ad   [EW];
  logic            sq_neg  [EW];
  logic            sq_pos  [EW];
  logic            sq_in   [EW];

  for (genvar k = 0; k < EW; k++) begin : g_sqrt
    logic [RADW-1:0] rad_i;
    logic [EW+1:0]   rem_i;
    logic [EW-1:0]   root_i;
    logic [EW-1:0]   ad_i;
    logic            neg_i, pos_i, in_i;
    logic [EW+1:0]   cand;
    logic [EW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rad_i  = s3_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign ad_i   = s3_ad;
      assign neg_i  = s3_neg;
      assign pos_i  = s3_pos;
      assign in_i   = s3_in;
    end else begin : g_next
      assign rad_i  = sq_rad[k-1];
      assign rem_i  = sq_rem[k-1];
      assign root_i = sq_root[k-1];
      assign ad_i   = sq_ad[k-1];
      assign neg_i  = sq_neg[k-1];
      assign pos_i  = sq_pos[k-1];
      assign in_i   = sq_in[k-1];
    end

    assign cand  = {rem_i[EW-1:0], rad_i[2*(EW-1-k)+1 -: 2]};
    assign trial = {root_i, 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k]  <= ge ? (cand - trial) : cand;
        sq_root[k] <= {root_i[EW-2:0], ge};
        sq_rad[k]  <= rad_i;
        sq_ad[k]   <= ad_i;
        sq_neg[k]  <= neg_i;
        sq_pos[k]  <= pos_i;
        sq_in[k]   <= in_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage P: lambda magnitude, region, delta partial products
  // ---------------------------------------------------------------------
  logic [EW-1:0]     root_f;
  logic [EW-1:0]     s_val;
  logic [EW-1:0]     p_mag;
  logic              p_neg;
  sbc_pkg::region_t  p_region;
  logic [PDW-1:0]    p_dlo, p_dhi;

  assign root_f = sq_root[EW-1];
  // delta is zero outside the band: feed a zero root into its product
  assign s_val  = sq_in[EW-1] ? root_f : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      p_mag    <= sq_in[EW-1] ? sq_ad[EW-1] : (sq_ad[EW-1] - root_f);
      p_neg    <= sq_in[EW-1] ? sq_neg[EW-1] : !sq_pos[EW-1];
      p_region <= sq_in[EW-1] ? sbc_pkg::REGION_INSIDE :
                  (sq_pos[EW-1] ? sbc_pkg::REGION_ABOVE : sbc_pkg::REGION_BELOW);
      p_dlo    <= PDW'(v2[HW-1:0]) * PDW'(s_val);
      p_dhi    <= PDW'(v2[V2W-1:HW]) * PDW'(s_val);
    end
  end

  // Stage Q: delta numerator 2*v2*s, lambda partial products
  logic [NDW-1:0]   q_nd;
  logic [PLW-1:0]   q_l0, q_l1, q_l2;
  logic             q_neg;
  sbc_pkg::region_t q_region;

  always_ff @(posedge clk) begin
    if (en) begin
      q_nd     <= (NDW'(p_dlo) + (NDW'(p_dhi) << HW)) << 1;
      q_l0     <= PLW'(pi_v2[CH-1:0]) * PLW'(p_mag);
      q_l1     <= PLW'(pi_v2[2*CH-1:CH]) * PLW'(p_mag);
      q_l2     <= PLW'(pi_v2[PVW-1:2*CH]) * PLW'(p_mag);
      q_neg    <= p_neg;
      q_region <= p_region;
    end
  end

  // Stage R: lambda numerator pi*v2*|t|
  logic [NDW-1:0]   r_nd;
  logic [NLW-1:0]   r_nl;
  logic             r_neg;
  sbc_pkg::region_t r_region;

  always_ff @(posedge clk) begin
    if (en) begin
      r_nd     <= q_nd;
      r_nl     <= NLW'(q_l0) + (NLW'(q_l1) << CH) + (NLW'(q_l2) << (2 * CH));
      r_neg    <= q_neg;
      r_region <= q_region;
    end
  end

  // Stage S: overflow checks ahead of the dividers
  logic [DDW-1:0]   s_nd;
  logic [LDW-1:0]   s_nl;
  logic             s_dsat, s_lsat, s_neg;
  sbc_pkg::region_t s_region;

  always_ff @(posedge clk) begin
    if (en) begin
      s_nd     <= DDW'(r_nd);
      s_nl     <= LDW'(r_nl);
      s_dsat   <= DDW'(r_nd) >= (DDW'(w2) << (RW - 1));
      s_lsat   <= LDW'(r_nl) >= (LDW'(w_eff) << (sbc_pkg::LAMBDA_SHIFT + RW));
      s_neg    <= r_neg;
      s_region <= r_region;
    end
  end

  // ---------------------------------------------------------------------
  // Restoring dividers: delta by w^2, lambda by w*2^46, one bit per stage
  // ---------------------------------------------------------------------
  logic [DDW-1:0]   dv_dr   [RW];
  logic [RW-1:0]    dv_dq   [RW];
  logic [LDW-1:0]   dv_lr   [RW];
  logic [RW-1:0]    dv_lq   [RW];
  logic             dv_dsat [RW];
  logic             dv_lsat [RW];
  logic             dv_neg  [RW];
  sbc_pkg::region_t dv_reg  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_div
    localparam int B = RW - 1 - k;
    logic [DDW-1:0]   dr_i, dsub;
    logic [LDW-1:0]   lr_i, lsub;
    logic [RW-1:0]    dq_i, lq_i;
    logic             dsat_i, lsat_i, neg_i;
    sbc_pkg::region_t reg_i;
    logic             dge, lge;

    if (k == 0) begin : g_first
      assign dr_i   = s_nd;
      assign lr_i   = s_nl;
      assign dq_i   = '0;
      assign lq_i   = '0;
      assign dsat_i = s_dsat;
      assign lsat_i = s_lsat;
      assign neg_i  = s_neg;
      assign reg_i  = s_region;
    end else begin : g_next
      assign dr_i   = dv_dr[k-1];
      assign lr_i   = dv_lr[k-1];
      assign dq_i   = dv_dq[k-1];
      assign lq_i   = dv_lq[k-1];
      assign dsat_i = dv_dsat[k-1];
      assign lsat_i = dv_lsat[k-1];
      assign neg_i  = dv_neg[k-1];
      assign reg_i  = dv_reg[k-1];
    end

    assign dsub = DDW'(w2) << B;
    assign lsub = LDW'(w_eff) << (sbc_pkg::LAMBDA_SHIFT + B);
    assign dge  = dr_i >= dsub;
    assign lge  = lr_i >= lsub;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_dr[k]   <= dge ? (dr_i - dsub) : dr_i;
        dv_lr[k]   <= lge ? (lr_i - lsub) : lr_i;
        dv_dq[k]   <= {dq_i[RW-2:0], dge};
        dv_lq[k]   <= {lq_i[RW-2:0], lge};
        dv_dsat[k] <= dsat_i;
        dv_lsat[k] <= lsat_i;
        dv_neg[k]  <= neg_i;
        dv_reg[k]  <= reg_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: clip, apply sign, hold while stalled
  // ---------------------------------------------------------------------
  localparam logic [RW-1:0] HALF = RW'(1) << (RW - 1);

  logic [RW-1:0]    lq_f;
  logic [RW-1:0]    lim;
  logic             lclip;
  logic [RW-1:0]    lmag;
  logic [RW-2:0]    o_delta;
  logic [RW-1:0]    o_lambda;
  sbc_pkg::region_t o_region;
  logic             o_sat;

  assign lq_f  = dv_lq[RW-1];
  // negative results may reach one step further than positive ones
  assign lim   = dv_neg[RW-1] ? HALF : (HALF - 1'b1);
  assign lclip = dv_lsat[RW-1] || (lq_f > lim);
  assign lmag  = lclip ? lim : lq_f;

  always_ff @(posedge clk) begin
    if (en) begin
      o_delta  <= dv_dsat[RW-1] ? {(RW-1){1'b1}} : dv_dq[RW-1][RW-2:0];
      o_lambda <= dv_neg[RW-1] ? (~lmag + 1'b1) : lmag;
      o_region <= dv_reg[RW-1];
      o_sat    <= dv_dsat[RW-1] || lclip;
    end
  end

  assign delta_value  = o_delta;
  assign lambda_value = o_lambda;
  assign region       = o_region;
  assign saturated    = o_sat;

`ifndef SYNTHESIS
  // outside the band the width is exactly zero
  a_delta_zero_outside: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (region != sbc_pkg::REGION_INSIDE)) |-> (delta_value == '0))
    else $error("delta nonzero outside band");

  // above the band the shift is never negative
  a_lambda_above_sign: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (region == sbc_pkg::REGION_ABOVE)) |-> !lambda_value[RW-1])
    else $error("negative lambda above band");

  // below the band the shift is never positive
  a_lambda_below_sign: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (region == sbc_pkg::REGION_BELOW)) |->
      (lambda_value[RW-1] || (lambda_value == '0)))
    else $error("positive lambda below band");

  // a stalled result must survive into the next cycle
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(lambda_value)))
    else $error("result dropped under stall");
`endif

endmodule

// File: dv/tb_semielliptic_band_chemisorption.sv
// Self-checking testbench for semielliptic_band_chemisorption.
// Depends on sbc_pkg and the block under test; carries its own predictor.
module tb_semielliptic_band_chemisorption;

  localparam int EW = 24;
  localparam int RW = 32;
  // pipeline depth plus margin
  localparam int DRAIN_CYCLES = EW + RW + 7 + 16;
  // idle cycles with no transaction on either side before the run is declared hung
  localparam int HANG_LIMIT = 5000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 135;

  localparam logic [3:0] ADDR_COUPLING    = 4'(sbc_pkg::REG_COUPLING) << 2;
  localparam logic [3:0] ADDR_BAND_CENTRE = 4'(sbc_pkg::REG_BAND_CENTRE) << 2;
  localparam logic [3:0] ADDR_BAND_WIDTH  = 4'(sbc_pkg::REG_BAND_WIDTH) << 2;
  // no register lives here; writes must be dropped
  localparam logic [3:0] ADDR_UNUSED      = 4'd12;

  typedef struct packed {
    logic [RW-2:0]        delta;
    logic signed [RW-1:0] lambda;
    sbc_pkg::region_t     region;
    logic                 sat;
  } outcome_t;

  typedef struct {
    logic signed [EW-1:0] energy;
    bit                   known;
    outcome_t             outcome;
  } sample_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 energy_valid = 1'b0;
  logic                 energy_stall;
  logic signed [EW-1:0] energy = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [RW-2:0]        delta_value;
  logic signed [RW-1:0] lambda_value;
  logic [1:0]           region;
  logic                 saturated;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [3:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  semielliptic_band_chemisorption #(.ENERGY_WIDTH(EW), .RESULT_WIDTH(RW)) i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block's registers, as the predictor sees them
  logic [EW-2:0]        coupling_q;
  logic signed [EW-1:0] band_centre_q;
  logic [EW-2:0]        band_width_q;

  outcome_t pending_results[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       sat_seen = 0;
  int       region_seen[3] = '{0, 0, 0};
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       quiet_cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitpos;
    root = '0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos >>= 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  // Hybridization width and its Hilbert-transform shift for one energy sample.
  function automatic outcome_t chemisorb(logic signed [EW-1:0] e);
    longint       d;
    logic [63:0]  ad, w, root, mag, lim;
    logic [127:0] v2, q;
    bit           neg;
    outcome_t     o;
    d = longint'(e) - longint'(band_centre_q);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    w = (band_width_q == 0) ? 64'd1 : 64'(band_width_q);
    v2 = 128'(coupling_q) * 128'(coupling_q);
    o.delta = '0;
    o.sat = 1'b0;
    if (ad <= w) begin
      root = int_sqrt(w * w - ad * ad);
      o.region = sbc_pkg::REGION_INSIDE;
      q = ((128'd2 * v2 * 128'(root)) / 128'(w)) / 128'(w);
      if (q > 128'((64'd1 << (RW - 1)) - 1)) begin
        o.delta = '1;
        o.sat = 1'b1;
      end else begin
        o.delta = q[RW-2:0];
      end
      mag = ad;
      neg = (d < 0);
    end else begin
      root = int_sqrt(ad * ad - w * w);
      o.region = (d > 0) ? sbc_pkg::REGION_ABOVE : sbc_pkg::REGION_BELOW;
      mag = ad - root;
      neg = (o.region == sbc_pkg::REGION_BELOW);
    end
    q = ((v2 * 128'(sbc_pkg::PI_Q) * 128'(mag)) / 128'(w)) >> sbc_pkg::LAMBDA_SHIFT;
    // negative side reaches one step further
    lim = neg ? (64'd1 << (RW - 1)) : (64'd1 << (RW - 1)) - 1;
    if (q > 128'(lim)) begin
      q = 128'(lim);
      o.sat = 1'b1;
    end
    o.lambda = neg ? -q[RW-1:0] : q[RW-1:0];
    return o;
  endfunction

  // Run one APB write; mirror it into the shadow registers at the write edge.
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready) begin
      case (addr)
        ADDR_COUPLING:    coupling_q = data[EW-2:0];
        ADDR_BAND_CENTRE: band_centre_q = data[EW-1:0];
        ADDR_BAND_WIDTH:  band_width_q = data[EW-2:0];
        default: ;
      endcase
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // leave the bus idle before the next write
    @(negedge clk);
  endtask

  // Offer one sample; hold it until the block takes it. Enter and leave on a falling edge.
  task automatic send_energy(input logic signed [EW-1:0] e, input bit known,
                             input outcome_t typed);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      energy_valid <= 1'b0;
      energy <= EW'($urandom);
      @(negedge clk);
    end
    energy_valid <= 1'b1;
    energy <= e;
    do @(posedge clk); while (energy_stall);
    pending_results.push_back(known ? typed : chemisorb(e));
    @(negedge clk);
  endtask

  // Drop valid, let the pipe empty, then wait out its depth before touching registers.
  task automatic drain;
    energy_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Energies cluster around the band and its edges; the rest span the full field.
  function automatic logic signed [EW-1:0] pick_energy;
    longint w, c, off;
    w = (band_width_q == 0) ? 1 : longint'(band_width_q);
    c = longint'(band_centre_q);
    case ($urandom_range(9))
      0, 1: return EW'($urandom);
      2: off = $urandom_range(1) ? w : -w;
      3: off = ($urandom_range(1) ? w : -w) + longint'($urandom_range(2)) - 1;
      default: off = longint'($urandom_range(32'(4 * w))) - 2 * w;
    endcase
    c += off;
    if (c > 8388607 || c < -8388608) return EW'($urandom);
    return EW'(c);
  endfunction

  // Receiver: stall at random as the current profile asks.
  always @(negedge clk)
    result_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

  // Compare every delivered result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting: delta %0d lambda %0d",
               delta_value, lambda_value);
        mismatches++;
      end else begin
        outcome_t exp_o;
        exp_o = pending_results.pop_front();
        results_seen++;
        if (exp_o.sat) sat_seen++;
        region_seen[exp_o.region]++;
        if (delta_value !== exp_o.delta) begin
          $error("delta_value: expected %0d, got %0d", exp_o.delta, delta_value);
          mismatches++;
        end
        if (lambda_value !== exp_o.lambda) begin
          $error("lambda_value: expected %0d, got %0d", exp_o.lambda, lambda_value);
          mismatches++;
        end
        if (region !== exp_o.region) begin
          $error("region: expected %0d, got %0d", exp_o.region, region);
          mismatches++;
        end
        if (saturated !== exp_o.sat) begin
          $error("saturated: expected %0d, got %0d", exp_o.sat, saturated);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((energy_valid && !energy_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               HANG_LIMIT, pending_results.size());
      $display("semielliptic_band_chemisorption regression: fail");
      $finish;
    end
  end

  // Directed samples at the reset setting: V = 1.0, centre 0, half width 1.0.
  // Band centre gives Delta = 2.0 and no shift; the edges give Delta 0 and
  // Lambda = +-floor(PI_Q / 2^14).
  sample_row_t directed[] = '{
    '{24'sd0,       1'b1, '{31'd131072, 32'sd0,       sbc_pkg::REGION_INSIDE, 1'b0}},
    '{24'sd65536,   1'b1, '{31'd0,      32'sd205887,  sbc_pkg::REGION_INSIDE, 1'b0}},
    '{-24'sd65536,  1'b1, '{31'd0,      -32'sd205887, sbc_pkg::REGION_INSIDE, 1'b0}},
    '{24'sd65537,   1'b0, '0},
    '{-24'sd65537,  1'b0, '0},
    '{24'sd1,       1'b0, '0},
    '{-24'sd1,      1'b0, '0},
    '{24'sd32768,   1'b0, '0},
    '{-24'sd32768,  1'b0, '0},
    '{24'sd131072,  1'b0, '0},
    '{-24'sd131072, 1'b0, '0},
    '{24'sd8388607, 1'b0, '0},
    '{-24'sd8388608,1'b0, '0},
    '{24'sh555555,  1'b0, '0},
    '{24'shAAAAAA,  1'b0, '0}
  };

  initial begin
    logic [31:0] cp, ce, bw;
    coupling_q = (EW-1)'(sbc_pkg::COUPLING_RESET);
    band_centre_q = '0;
    band_width_q = (EW-1)'(sbc_pkg::BAND_WIDTH_RESET);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 85;
    foreach (directed[k]) send_energy(directed[k].energy, directed[k].known, directed[k].outcome);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // first third: slow receiver; second: slow sender; last: full rate
      if (p < 4) begin
        send_idle_pct = 23;
        recv_idle_pct = 85;
      end else if (p < 8) begin
        send_idle_pct = 85;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cp = $urandom;
      ce = $urandom;
      bw = $urandom;
      // upper bits stay random so truncation on the port is exercised
      case (p)
        0: begin cp[22:0] = '1; ce[23:0] = '0;          bw[22:0] = 23'd1; end
        1: begin cp[22:0] = '0;                          bw[22:0] = 23'd0; end
        2: begin cp[22:0] = '1; ce[23:0] = 24'h800000;   bw[22:0] = '1;    end
        3: begin                 ce[23:0] = 24'h7FFFFF;                    end
        4: begin cp[22:0] = 23'd65536; ce[23:0] = '0;    bw[22:0] = 23'd65536; end
        5: begin cp[22:0] = '1;                          bw[22:0] = 23'd0; end
        6: begin cp[22:0] = 23'(cp[17:0]);              bw[22:0] = 23'(bw[17:0]); end
        default: ;
      endcase
      reg_write(ADDR_COUPLING, cp);
      reg_write(ADDR_BAND_CENTRE, ce);
      reg_write(ADDR_BAND_WIDTH, bw);
      reg_write(ADDR_UNUSED, $urandom);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_energy(pick_energy(), 1'b0, '0);
      drain();
    end

    $display("covered %0d results over %0d register settings: %0d inside, %0d above,",
             results_seen, PHASES + 1, region_seen[sbc_pkg::REGION_INSIDE],
             region_seen[sbc_pkg::REGION_ABOVE]);
    $display("%0d below band, %0d clipped; %0d mismatching fields",
             region_seen[sbc_pkg::REGION_BELOW], sat_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("semielliptic_band_chemisorption regression: pass");
    else
      $display("semielliptic_band_chemisorption regression: fail");
    $finish;
  end

endmodule
